// ===== rtl/mrt_pkg.sv =====
// Shared widths, item kind codes and record types for the merged range table.
package mrt_pkg;

    localparam int TABLE_DEPTH_DEF = 64;

    localparam int ROW_W   = 21;
    localparam int COL_W   = 15;
    localparam int IDX_W   = 6;
    localparam int CNT_W   = 7;
    localparam int KIND_W  = 2;

    // Input beat: top row, left column, bottom row, right column, entry index.
    localparam int S_FIELDS_W = 2 * ROW_W + 2 * COL_W + IDX_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;

    // Result beat: ok, inside_res, follower, four bounds, entry_count.
    localparam int M_FIELDS_W = 3 + 2 * ROW_W + 2 * COL_W + CNT_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    localparam int ROW_MEM_W = 2 * ROW_W;
    localparam int COL_MEM_W = 2 * COL_W;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd3;

    typedef struct packed {
        logic hit;
        logic follower;
    } match_t;

    typedef struct packed {
        logic             ok;
        logic             inside_res;
        logic             follower;
        logic [ROW_W-1:0] top_row;
        logic [COL_W-1:0] left_col;
        logic [ROW_W-1:0] bottom_row;
        logic [COL_W-1:0] right_col;
    } res_t;

endpackage

// ===== rtl/mrt_ram.sv =====
// Generic single-port-write, registered-read synchronous RAM.
module mrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/mrt_match.sv =====
// Containment and master-cell test of one point against one stored range.
module mrt_match (
    input  logic [mrt_pkg::ROW_W-1:0]     pt_row,
    input  logic [mrt_pkg::COL_W-1:0]     pt_col,
    input  logic [mrt_pkg::ROW_MEM_W-1:0] row_word,
    input  logic [mrt_pkg::COL_MEM_W-1:0] col_word,
    output mrt_pkg::match_t               result
);
    import mrt_pkg::*;

    logic [ROW_W-1:0] row_lo, row_hi;
    logic [COL_W-1:0] col_lo, col_hi;

    assign row_lo = row_word[ROW_W-1:0];
    assign row_hi = row_word[2*ROW_W-1:ROW_W];
    assign col_lo = col_word[COL_W-1:0];
    assign col_hi = col_word[2*COL_W-1:COL_W];

    always_comb begin
        result.hit = (pt_row >= row_lo) && (pt_row <= row_hi) &&
                     (pt_col >= col_lo) && (pt_col <= col_hi);
        // Any cell other than the top-left corner is a follower.
        result.follower = !((pt_row == row_lo) && (pt_col == col_lo));
    end

endmodule

// ===== rtl/merged_range_table_unit.sv =====
// Top level of the merged range table: sequencer, bound memories and result stage.
//
// The table keeps up to TABLE_DEPTH rectangular ranges in two synchronous RAMs
// (row bounds and column bounds) and handles one beat at a time. A valid read
// passes through a read-wait state before its result; a point query walks the
// RAM in insertion order, one entry per cycle through the single read port, and
// stops at the first range that contains the point. No clearing pass is needed
// after reset; entries beyond the stored count are never read. A new beat is
// accepted while the previous result still waits in the output register.
module merged_range_table_unit #(
    parameter int TABLE_DEPTH = mrt_pkg::TABLE_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // From bit 0: top row, left column, bottom row, right column, entry index.
    input  logic [mrt_pkg::S_TDATA_W-1:0]  s_tdata,
    // kind
    input  logic [mrt_pkg::KIND_W-1:0]     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // From bit 0: ok, inside flag, follower flag, top row, left column,
    // bottom row, right column, entry count.
    output logic [mrt_pkg::M_TDATA_W-1:0]  m_tdata
);
    import mrt_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int IW = (CW > IDX_W) ? CW : IDX_W;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EXEC   = 3'd1;
    localparam logic [2:0] ST_RDWAIT = 3'd2;
    localparam logic [2:0] ST_SCAN   = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] scan_idx_reg, scan_idx_next;

    logic [KIND_W-1:0] kind_reg;
    logic [ROW_W-1:0]  in_top_row_reg, in_bottom_row_reg;
    logic [COL_W-1:0]  in_left_col_reg, in_right_col_reg;
    logic [IDX_W-1:0]  in_index_reg;

    res_t res_reg, res_next;
    logic m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;

    logic s_accept, out_free;
    logic wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [ROW_MEM_W-1:0] row_rd;
    logic [COL_MEM_W-1:0] col_rd;
    match_t match;
    logic read_ok;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign read_ok  = IW'(in_index_reg) < IW'(count_reg);

    mrt_ram #(.WIDTH(ROW_MEM_W), .DEPTH(TABLE_DEPTH)) u_row_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data ({in_bottom_row_reg, in_top_row_reg}),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (row_rd)
    );

    mrt_ram #(.WIDTH(COL_MEM_W), .DEPTH(TABLE_DEPTH)) u_col_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data ({in_right_col_reg, in_left_col_reg}),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (col_rd)
    );

    mrt_match u_match (
        .pt_row   (in_top_row_reg),
        .pt_col   (in_left_col_reg),
        .row_word (row_rd),
        .col_word (col_rd),
        .result   (match)
    );

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        scan_idx_next = scan_idx_reg;
        res_next      = res_reg;
        wr_en         = 1'b0;
        wr_addr       = AW'(count_reg);
        rd_en         = 1'b0;
        rd_addr       = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                res_next            = '0;
                res_next.ok         = 1'b1;
                state_next          = ST_FINISH;
                case (kind_reg)
                    KIND_INSERT: begin
                        if (in_top_row_reg != '0 && in_left_col_reg != '0 &&
                            count_reg < CW'(TABLE_DEPTH)) begin
                            wr_en      = 1'b1;
                            count_next = count_reg + CW'(1);
                        end else begin
                            res_next.ok = 1'b0;
                        end
                    end
                    KIND_QUERY: begin
                        scan_idx_next = '0;
                        if (count_reg != '0) begin
                            rd_en      = 1'b1;
                            rd_addr    = '0;
                            state_next = ST_SCAN;
                        end
                    end
                    KIND_READ: begin
                        if (read_ok) begin
                            rd_en      = 1'b1;
                            rd_addr    = AW'(IW'(in_index_reg));
                            state_next = ST_RDWAIT;
                        end else begin
                            res_next.ok = 1'b0;
                        end
                    end
                    KIND_CLEAR: begin
                        count_next = '0;
                    end
                    default: begin
                        res_next.ok = 1'b1;
                    end
                endcase
            end
            ST_RDWAIT: begin
                res_next.top_row    = row_rd[ROW_W-1:0];
                res_next.bottom_row = row_rd[2*ROW_W-1:ROW_W];
                res_next.left_col   = col_rd[COL_W-1:0];
                res_next.right_col  = col_rd[2*COL_W-1:COL_W];
                state_next          = ST_FINISH;
            end
            ST_SCAN: begin
                // Read data belongs to entry scan_idx_reg; fetch the next one meanwhile.
                if (match.hit) begin
                    res_next.inside_res = 1'b1;
                    res_next.follower   = match.follower;
                    state_next          = ST_FINISH;
                end else if (scan_idx_reg + CW'(1) == count_reg) begin
                    state_next = ST_FINISH;
                end else begin
                    scan_idx_next = scan_idx_reg + CW'(1);
                    rd_en         = 1'b1;
                    rd_addr       = AW'(scan_idx_next);
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            scan_idx_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            scan_idx_reg <= scan_idx_next;
            if (state_reg == ST_FINISH && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
        if (s_accept) begin
            kind_reg          <= s_tuser;
            in_top_row_reg    <= s_tdata[ROW_W-1:0];
            in_left_col_reg   <= s_tdata[ROW_W+COL_W-1:ROW_W];
            in_bottom_row_reg <= s_tdata[2*ROW_W+COL_W-1:ROW_W+COL_W];
            in_right_col_reg  <= s_tdata[2*ROW_W+2*COL_W-1:2*ROW_W+COL_W];
            in_index_reg      <= s_tdata[S_FIELDS_W-1:2*ROW_W+2*COL_W];
        end
        if (state_reg == ST_FINISH && out_free) begin
            m_data_reg <= M_TDATA_W'({CNT_W'(count_reg), res_reg.right_col,
                                      res_reg.bottom_row, res_reg.left_col,
                                      res_reg.top_row, res_reg.follower,
                                      res_reg.inside_res, res_reg.ok});
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ===== tb/merged_range_table_checker.sv =====
// Result checker for the merged range table: predicts every result beat and compares it.
module merged_range_table_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    // From bit 0: top row, left column, bottom row, right column, entry index.
    input  logic [mrt_pkg::S_TDATA_W-1:0] s_tdata,
    // kind
    input  logic [mrt_pkg::KIND_W-1:0]    s_tuser,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    // From bit 0: ok, inside flag, follower flag, top row, left column,
    // bottom row, right column, entry count.
    input  logic [mrt_pkg::M_TDATA_W-1:0] m_tdata,
    output int                            mismatch_count,
    output int                            answers_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import mrt_pkg::*;

    // Packed so that the last member sits at bit 0, matching the beat layout.
    typedef struct packed {
        logic [IDX_W-1:0] entry_index;
        logic [COL_W-1:0] col_hi;
        logic [ROW_W-1:0] row_hi;
        logic [COL_W-1:0] col_lo;
        logic [ROW_W-1:0] row_lo;
    } range_cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0] entry_count;
        logic [COL_W-1:0] col_hi;
        logic [ROW_W-1:0] row_hi;
        logic [COL_W-1:0] col_lo;
        logic [ROW_W-1:0] row_lo;
        logic             follower;
        logic             inside_res;
        logic             ok;
    } range_answer_t;

    logic [ROW_W-1:0] top_row    [TABLE_DEPTH_DEF];
    logic [ROW_W-1:0] bottom_row [TABLE_DEPTH_DEF];
    logic [COL_W-1:0] left_col   [TABLE_DEPTH_DEF];
    logic [COL_W-1:0] right_col  [TABLE_DEPTH_DEF];
    int               stored_ranges;
    range_answer_t    answer_q[$];

    function automatic range_answer_t predict_answer(logic [KIND_W-1:0] kind,
                                                     range_cmd_t cmd);
        range_answer_t a;
        a = '0;
        case (kind)
            KIND_INSERT: begin
                if (cmd.row_lo != 0 && cmd.col_lo != 0 &&
                    stored_ranges < TABLE_DEPTH_DEF) begin
                    top_row[stored_ranges]    = cmd.row_lo;
                    bottom_row[stored_ranges] = cmd.row_hi;
                    left_col[stored_ranges]   = cmd.col_lo;
                    right_col[stored_ranges]  = cmd.col_hi;
                    stored_ranges++;
                    a.ok = 1'b1;
                end
            end
            KIND_QUERY: begin
                a.ok = 1'b1;
                // Only the first range in insertion order decides the follower flag.
                for (int i = 0; i < stored_ranges; i++) begin
                    if (cmd.row_lo >= top_row[i] && cmd.row_lo <= bottom_row[i] &&
                        cmd.col_lo >= left_col[i] && cmd.col_lo <= right_col[i]) begin
                        a.inside_res = 1'b1;
                        a.follower   = !(cmd.row_lo == top_row[i] &&
                                         cmd.col_lo == left_col[i]);
                        break;
                    end
                end
            end
            KIND_READ: begin
                if (cmd.entry_index < stored_ranges) begin
                    a.ok     = 1'b1;
                    a.row_lo = top_row[cmd.entry_index];
                    a.row_hi = bottom_row[cmd.entry_index];
                    a.col_lo = left_col[cmd.entry_index];
                    a.col_hi = right_col[cmd.entry_index];
                end
            end
            default: begin
                stored_ranges = 0;
                a.ok          = 1'b1;
            end
        endcase
        a.entry_count = CNT_W'(stored_ranges);
        return a;
    endfunction

    task automatic compare_field(string name, longint unsigned want, longint unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        range_answer_t want;
        range_answer_t got;
        if (!aresetn) begin
            answer_q.delete();
            stored_ranges = 0;
            mismatch_count = 0;
            answers_pending <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = range_answer_t'(m_tdata[M_FIELDS_W-1:0]);
                if (answer_q.size() == 0) begin
                    $display("%0t: result beat with nothing expected, expected none, actual %h",
                             $time, m_tdata);
                    mismatch_count++;
                end else begin
                    want = answer_q.pop_front();
                    compare_field("ok", want.ok, got.ok);
                    compare_field("inside_res", want.inside_res, got.inside_res);
                    compare_field("follower", want.follower, got.follower);
                    compare_field("top row", want.row_lo, got.row_lo);
                    compare_field("left column", want.col_lo, got.col_lo);
                    compare_field("bottom row", want.row_hi, got.row_hi);
                    compare_field("right column", want.col_hi, got.col_hi);
                    compare_field("entry_count", want.entry_count, got.entry_count);
                end
            end
            if (s_tvalid && s_tready)
                answer_q.push_back(predict_answer(s_tuser,
                                                  range_cmd_t'(s_tdata[S_FIELDS_W-1:0])));
            answers_pending <= answer_q.size();
        end
    end

endmodule

// ===== tb/merged_range_table_unit_test.sv =====
// Testbench top for the merged range table: clock, reset, stimulus, stalls and verdict.
module merged_range_table_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import mrt_pkg::*;

    localparam int MAX_ROW        = 1048576;
    localparam int MAX_COL        = 16384;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = TABLE_DEPTH_DEF + 16;

    typedef enum {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_BLOCKS} rx_pattern_e;

    typedef struct {
        int fr;
        int fc;
        int lr;
        int lc;
    } rect_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic [KIND_W-1:0]     s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    int          mismatch_count;
    int          answers_pending;
    int          idle_cycles;
    int          burst_left;
    int          est_fill;
    rect_t       recent_q[$];
    rx_pattern_e rx_mode = RX_OPEN;
    int          rx_left;

    merged_range_table_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    merged_range_table_checker table_monitor (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .mismatch_count  (mismatch_count),
        .answers_pending (answers_pending)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // The receiver switches at random between stall patterns.
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode <= rx_pattern_e'($urandom_range(0, 3));
            rx_left <= $urandom_range(16, 96);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_OPEN:  m_tready <= 1'b1;
            RX_LIGHT: m_tready <= ($urandom_range(0, 3) != 0);
            RX_HEAVY: m_tready <= ($urandom_range(0, 4) == 0);
            default:  m_tready <= rx_left[3];
        endcase
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_beat(input logic [KIND_W-1:0] kind, input int fr, input int fc,
                             input int lr, input int lc, input int ix);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= S_TDATA_W'({IDX_W'(ix), COL_W'(lc), ROW_W'(lr), COL_W'(fc), ROW_W'(fr)});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Holds the input idle until every outstanding result beat has been taken.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (answers_pending != 0) @(posedge aclk);
    endtask

    task automatic random_item(input int insert_pct, input int clear_per_mille);
        logic [KIND_W-1:0] kind;
        int                fr, fc, lr, lc, ix, roll;
        rect_t             r;
        fr = $urandom_range(0, MAX_ROW);
        fc = $urandom_range(0, MAX_COL);
        lr = $urandom_range(0, MAX_ROW);
        lc = $urandom_range(0, MAX_COL);
        ix = $urandom_range(0, 63);
        roll = $urandom_range(0, 99);
        if ($urandom_range(0, 999) < clear_per_mille)
            kind = KIND_CLEAR;
        else if (roll < insert_pct)
            kind = KIND_INSERT;
        else if (roll < insert_pct + (100 - insert_pct) * 3 / 5)
            kind = KIND_QUERY;
        else
            kind = KIND_READ;

        case (kind)
            KIND_INSERT: begin
                // Mostly small ranges near the origin so that queries overlap them.
                if ($urandom_range(0, 3) != 0) begin
                    fr = $urandom_range(1, 40);
                    fc = $urandom_range(1, 40);
                end
                lr = fr + $urandom_range(0, 6);
                lc = fc + $urandom_range(0, 6);
                roll = $urandom_range(0, 39);
                if (roll == 0) begin
                    fr = 0;
                end else if (roll == 1) begin
                    fc = 0;
                end else if (roll < 4) begin
                    lr = fr / 2;
                end else if (roll < 6) begin
                    lc = fc / 2;
                end else if (roll == 6) begin
                    lr = MAX_ROW;
                    lc = MAX_COL;
                end
                if (lr > MAX_ROW) lr = MAX_ROW;
                if (lc > MAX_COL) lc = MAX_COL;
                if (fr != 0 && fc != 0 && est_fill < TABLE_DEPTH_DEF) est_fill++;
                recent_q.push_back('{fr, fc, lr, lc});
                if (recent_q.size() > 16) void'(recent_q.pop_front());
            end
            KIND_QUERY: begin
                if (recent_q.size() != 0 && $urandom_range(0, 9) < 7) begin
                    r = recent_q[$urandom_range(0, recent_q.size() - 1)];
                    case ($urandom_range(0, 4))
                        0: begin fr = r.fr; fc = r.fc; end
                        1: begin fr = r.lr; fc = r.lc; end
                        2: begin
                            fr = $urandom_range(r.fr, r.lr);
                            fc = $urandom_range(r.fc, r.lc);
                        end
                        3: begin fr = r.lr + 1; fc = r.fc; end
                        default: begin
                            fr = r.fr;
                            fc = (r.fc > 0) ? r.fc - 1 : 0;
                        end
                    endcase
                    if (fr > MAX_ROW) fr = MAX_ROW;
                    if (fc > MAX_COL) fc = MAX_COL;
                end else if ($urandom_range(0, 1) == 1) begin
                    fr = $urandom_range(0, 48);
                    fc = $urandom_range(0, 48);
                end
            end
            KIND_READ: begin
                if ($urandom_range(0, 4) != 0)
                    ix = $urandom_range(0, (est_fill > 63) ? 63 : est_fill);
            end
            default: begin
                est_fill = 0;
                recent_q.delete();
            end
        endcase
        send_beat(kind, fr, fc, lr, lc, ix);
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Empty table, rejected corners, extremes, overlaps and an inverted range.
        send_beat(KIND_READ,   0, 0, 0, 0, 0);
        send_beat(KIND_QUERY,  1, 1, 0, 0, 0);
        send_beat(KIND_INSERT, 0, 5, 10, 10, 0);
        send_beat(KIND_INSERT, 5, 0, 10, 10, 0);
        send_beat(KIND_INSERT, 1, 1, 1, 1, 0);
        send_beat(KIND_INSERT, MAX_ROW, MAX_COL, MAX_ROW, MAX_COL, 0);
        send_beat(KIND_INSERT, 2, 2, 6, 6, 0);
        send_beat(KIND_INSERT, 3, 3, 8, 8, 0);
        send_beat(KIND_INSERT, 10, 10, 5, 5, 0);
        send_beat(KIND_QUERY,  1, 1, 0, 0, 0);
        send_beat(KIND_QUERY,  MAX_ROW, MAX_COL, 0, 0, 0);
        send_beat(KIND_QUERY,  2, 2, 0, 0, 0);
        // Master cell of the later range, but the earlier range matches first.
        send_beat(KIND_QUERY,  3, 3, 0, 0, 0);
        send_beat(KIND_QUERY,  6, 6, 0, 0, 0);
        send_beat(KIND_QUERY,  8, 7, 0, 0, 0);
        send_beat(KIND_QUERY,  10, 10, 0, 0, 0);
        send_beat(KIND_READ,   0, 0, 0, 0, 1);
        send_beat(KIND_READ,   0, 0, 0, 0, 4);
        send_beat(KIND_READ,   0, 0, 0, 0, 5);
        send_beat(KIND_READ,   0, 0, 0, 0, 63);
        send_beat(KIND_INSERT, 1, 1, MAX_ROW, MAX_COL, 0);
        send_beat(KIND_QUERY,  0, 0, 0, 0, 0);
        send_beat(KIND_QUERY,  500000, 9000, 0, 0, 0);
        send_beat(KIND_CLEAR,  0, 0, 0, 0, 0);
        send_beat(KIND_QUERY,  2, 2, 0, 0, 0);
        drain_results();

        // Insert-heavy run without clears, so the table fills and rejects inserts.
        repeat (140) random_item(65, 0);
        drain_results();
        random_item(0, 1000);
        repeat (130) random_item(40, 25);
        drain_results();
        repeat (130) random_item(35, 25);
        drain_results();

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
